// ----- rtl/lcf_pkg.sv -----
package lcf_pkg;

  // Input kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_MSG     = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  // Received message types and codes
  localparam logic [7:0] MSG_OFFER     = 8'd1;
  localparam logic [7:0] MSG_ACK       = 8'd3;
  localparam logic [7:0] CODE_OK       = 8'd0;
  localparam logic [7:0] CODE_OFFER_NG = 8'd1;
  localparam logic [7:0] CODE_ACK_NG   = 8'd4;

  // Sent message types and codes
  localparam logic [2:0] TX_DISCOVER = 3'd0;
  localparam logic [2:0] TX_REQUEST  = 3'd2;
  localparam logic [2:0] TX_RELEASE  = 3'd4;
  localparam logic [2:0] SCODE_NONE    = 3'd0;
  localparam logic [2:0] SCODE_ALLOC   = 3'd2;
  localparam logic [2:0] SCODE_EXTEND  = 3'd3;

  localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_ttl;
    logic [31:0] msg_addr;
    logic [31:0] msg_mask;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  send_type;
    logic [2:0]  send_code;
    logic [15:0] send_ttl;
    logic [31:0] send_addr;
    logic [31:0] send_mask;
    logic [3:0]  client_state;
    logic        lease_granted;
    logic        fault;
  } out_item_t;

endpackage

// ----- rtl/lease_client_fsm_core.sv -----
// Channel  Ports                                  Direction  Handshake
// in       in_valid, in_stall, in_data            input      valid / stall
// out      out_valid, out_stall, out_data         output     valid / stall
// cfg      cfg_valid, cfg_ready, cfg_data         input      valid / ready
//
// One transaction per cycle sustained while out_stall stays low; each item yields exactly one
// result on out_data, through the input register, then the result register.
// Synchronous active-low reset: init phase, lease fields and counters zero,
// wait_timeout = 10. cfg_ready is always high.
// in_stall rises only when the input register is full and a stalled result
// still occupies the result register.
module lease_client_fsm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcf_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  typedef enum logic [3:0] {
    ST_INIT        = 4'd0,
    ST_WAIT_OFFER  = 4'd1,
    ST_OFFER_RETRY = 4'd2,
    ST_WAIT_ACK    = 4'd3,
    ST_ACK_RETRY   = 4'd4,
    ST_IN_USE      = 4'd5,
    ST_EXT_RETRY   = 4'd6,
    ST_WAIT_EXT    = 4'd7,
    ST_EXIT        = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_OK_OFFER,
    EV_NG_OFFER,
    EV_OK_ACK,
    EV_NG_ACK,
    EV_UNEXPECTED,
    EV_UNKNOWN,
    EV_TIMEOUT,
    EV_HALF,
    EV_RELEASE
  } ev_t;

  phase_t              phase_r, phase_nxt;
  logic [31:0]         lease_addr_r, lease_addr_nxt;
  logic [31:0]         lease_mask_r, lease_mask_nxt;
  logic [15:0]         lease_time_r, lease_time_nxt;
  logic [15:0]         reply_cnt_r, reply_cnt_nxt;
  logic [14:0]         renew_cnt_r, renew_cnt_nxt;
  logic [15:0]         wait_timeout_r;

  logic                s1_valid_r;
  lcf_pkg::in_item_t   in_r;
  logic                out_valid_r;
  lcf_pkg::out_item_t  out_data_r;

  lcf_pkg::out_item_t  res;
  ev_t                 ev;
  logic                bad;
  logic                waiting;
  logic                out_free;
  logic                advance;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign waiting = (phase_r == ST_WAIT_OFFER) || (phase_r == ST_OFFER_RETRY) ||
                   (phase_r == ST_WAIT_ACK) || (phase_r == ST_ACK_RETRY) ||
                   (phase_r == ST_EXT_RETRY) || (phase_r == ST_WAIT_EXT);

  always_comb begin
    phase_nxt      = phase_r;
    lease_addr_nxt = lease_addr_r;
    lease_mask_nxt = lease_mask_r;
    lease_time_nxt = lease_time_r;
    reply_cnt_nxt  = reply_cnt_r;
    renew_cnt_nxt  = renew_cnt_r;
    ev             = EV_NONE;
    bad            = 1'b0;
    res            = '0;

    // Event decode; ok messages latch their lease fields first
    if (phase_r != ST_EXIT) begin
      case (in_r.kind)
        lcf_pkg::KIND_START: begin
          if (phase_r == ST_INIT) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_DISCOVER;
            res.send_code  = lcf_pkg::SCODE_NONE;
            phase_nxt      = ST_WAIT_OFFER;
            reply_cnt_nxt  = wait_timeout_r;
          end
        end
        lcf_pkg::KIND_MSG: begin
          if (in_r.msg_type == lcf_pkg::MSG_OFFER) begin
            if (in_r.msg_code == lcf_pkg::CODE_OK)           ev = EV_OK_OFFER;
            else if (in_r.msg_code == lcf_pkg::CODE_OFFER_NG) ev = EV_NG_OFFER;
            else                                              ev = EV_UNEXPECTED;
          end else if (in_r.msg_type == lcf_pkg::MSG_ACK) begin
            if (in_r.msg_code == lcf_pkg::CODE_OK)         ev = EV_OK_ACK;
            else if (in_r.msg_code == lcf_pkg::CODE_ACK_NG) ev = EV_NG_ACK;
            else                                            ev = EV_UNEXPECTED;
          end else begin
            ev = EV_UNKNOWN;
          end
          if (ev == EV_OK_OFFER || ev == EV_OK_ACK) begin
            lease_addr_nxt = in_r.msg_addr;
            lease_mask_nxt = in_r.msg_mask;
            lease_time_nxt = in_r.msg_ttl;
          end
        end
        lcf_pkg::KIND_RELEASE: begin
          ev = EV_RELEASE;
        end
        default: begin
          // one-second tick
          if (waiting) begin
            if (reply_cnt_r <= 16'd1) ev = EV_TIMEOUT;
            else reply_cnt_nxt = reply_cnt_r - 16'd1;
          end else if (phase_r == ST_IN_USE && renew_cnt_r != '0) begin
            renew_cnt_nxt = renew_cnt_r - 15'd1;
            if (renew_cnt_r == 15'd1) ev = EV_HALF;
          end
        end
      endcase
    end

    if (ev != EV_NONE) begin
      case (phase_r)
        ST_WAIT_OFFER, ST_OFFER_RETRY: begin
          if (ev == EV_OK_OFFER) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_REQUEST;
            res.send_code  = lcf_pkg::SCODE_ALLOC;
            res.send_ttl   = lease_time_nxt;
            res.send_addr  = lease_addr_nxt;
            res.send_mask  = lease_mask_nxt;
            phase_nxt      = ST_WAIT_ACK;
            reply_cnt_nxt  = wait_timeout_r;
          end else if (ev == EV_TIMEOUT && phase_r == ST_WAIT_OFFER) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_DISCOVER;
            res.send_code  = lcf_pkg::SCODE_NONE;
            phase_nxt      = ST_OFFER_RETRY;
            reply_cnt_nxt  = wait_timeout_r;
          end else if (ev == EV_TIMEOUT || ev == EV_NG_OFFER ||
                       ev == EV_UNKNOWN || ev == EV_UNEXPECTED) begin
            phase_nxt = ST_EXIT;
          end else begin
            bad = 1'b1;
          end
        end
        ST_WAIT_ACK, ST_ACK_RETRY, ST_WAIT_EXT, ST_EXT_RETRY: begin
          if (ev == EV_OK_ACK) begin
            phase_nxt         = ST_IN_USE;
            renew_cnt_nxt     = lease_time_nxt[15:1];
            res.lease_granted = 1'b1;
          end else if (ev == EV_TIMEOUT && phase_r == ST_WAIT_ACK) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_REQUEST;
            res.send_code  = lcf_pkg::SCODE_ALLOC;
            res.send_ttl   = lease_time_nxt;
            res.send_addr  = lease_addr_nxt;
            res.send_mask  = lease_mask_nxt;
            phase_nxt      = ST_ACK_RETRY;
            reply_cnt_nxt  = wait_timeout_r;
          end else if (ev == EV_TIMEOUT && phase_r == ST_WAIT_EXT) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_REQUEST;
            res.send_code  = lcf_pkg::SCODE_EXTEND;
            res.send_ttl   = lease_time_nxt;
            res.send_addr  = lease_addr_nxt;
            res.send_mask  = lease_mask_nxt;
            phase_nxt      = ST_EXT_RETRY;
            reply_cnt_nxt  = wait_timeout_r;
          end else if (ev == EV_TIMEOUT || ev == EV_NG_ACK ||
                       ev == EV_UNKNOWN || ev == EV_UNEXPECTED) begin
            phase_nxt = ST_EXIT;
          end else begin
            bad = 1'b1;
          end
        end
        ST_IN_USE: begin
          if (ev == EV_HALF) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_REQUEST;
            res.send_code  = lcf_pkg::SCODE_EXTEND;
            res.send_ttl   = lease_time_nxt;
            res.send_addr  = lease_addr_nxt;
            res.send_mask  = lease_mask_nxt;
            phase_nxt      = ST_WAIT_EXT;
            reply_cnt_nxt  = wait_timeout_r;
          end else if (ev == EV_OK_ACK) begin
            phase_nxt         = ST_IN_USE;
            renew_cnt_nxt     = lease_time_nxt[15:1];
            res.lease_granted = 1'b1;
          end else if (ev == EV_RELEASE) begin
            res.send_valid = 1'b1;
            res.send_type  = lcf_pkg::TX_RELEASE;
            res.send_code  = lcf_pkg::SCODE_NONE;
            res.send_addr  = lease_addr_nxt;
            phase_nxt      = ST_EXIT;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    if (bad) begin
      phase_nxt = ST_EXIT;
      res.fault = 1'b1;
    end
    res.client_state = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ST_INIT;
      lease_addr_r   <= '0;
      lease_mask_r   <= '0;
      lease_time_r   <= '0;
      reply_cnt_r    <= '0;
      renew_cnt_r    <= '0;
      wait_timeout_r <= lcf_pkg::WAIT_TIMEOUT_RST;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) wait_timeout_r <= cfg_data;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        if (in_valid) in_r <= in_data;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) out_data_r <= res;
      end
      if (advance) begin
        phase_r      <= phase_nxt;
        lease_addr_r <= lease_addr_nxt;
        lease_mask_r <= lease_mask_nxt;
        lease_time_r <= lease_time_nxt;
        reply_cnt_r  <= reply_cnt_nxt;
        renew_cnt_r  <= renew_cnt_nxt;
      end
    end
  end

  a_fault_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.fault |-> out_data_r.client_state == ST_EXIT)
    else $error("fault without exit state");

  a_grant_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.lease_granted |->
      out_data_r.client_state == ST_IN_USE && !out_data_r.send_valid)
    else $error("grant outside in-use or with a send");

  a_idle_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.send_valid |->
      out_data_r.send_type == '0 && out_data_r.send_code == '0 &&
      out_data_r.send_ttl == '0 && out_data_r.send_addr == '0 &&
      out_data_r.send_mask == '0)
    else $error("send fields nonzero with no message");

  a_exit_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ST_EXIT |=> phase_r == ST_EXIT)
    else $error("left exit phase");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline");

endmodule
